FILE: rtl/bmi_pkg.sv
// Shared types and constants for the binary modular inverse block.
// Used by bmi_datapath, bmi_ctrl and binary_modular_inverse; no dependencies.
`timescale 1ns / 1ps

package bmi_pkg;

    // Fixed widths of the request and response fields.
    localparam int ValueW = 32;
    localparam int ModW   = 31;

    // Sequencer states, one-hot.
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } bmi_state_t;

    // Operation of the shared step unit.
    typedef enum logic [1:0] {
        OP_HALVE_U = 2'd0,
        OP_HALVE_V = 2'd1,
        OP_SUB_U   = 2'd2,
        OP_SUB_V   = 2'd3
    } bmi_op_t;

    // Flags from the datapath to the sequencer.
    typedef struct packed {
        logic in_bad;
        logic u_one;
        logic v_one;
        logic u_zero;
        logic v_zero;
        logic u_even;
        logic v_even;
        logic u_ge_v;
    } bmi_status_t;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic    load;
        logic    step;
        logic    finish;
        logic    reject;
        bmi_op_t op;
    } bmi_cmd_t;

endpackage

FILE: rtl/bmi_datapath.sv
// Operand registers and the shared step unit of the binary modular inverse.
// Depends on bmi_pkg for the command and status structs.
`timescale 1ns / 1ps

module bmi_datapath
    import bmi_pkg::*;
#(
    parameter int WIDTH = 32
)
(
    input  logic               clk,
    input  logic [ValueW-1:0]  value,
    input  logic [ModW-1:0]    modulus,
    input  bmi_cmd_t           cmd,
    output bmi_status_t        status,
    output logic [ModW-1:0]    inverse,
    output logic               no_inverse
);

    // V starts as the full modulus, so the registers are at least ModW wide.
    localparam int VW = (WIDTH > ModW) ? WIDTH : ModW;
    localparam logic [VW-1:0] ONES  = '1;
    localparam logic [VW-1:0] WMASK = ONES >> (VW - WIDTH);

    logic [VW-1:0]   u_reg, u_next;
    logic [VW-1:0]   v_reg, v_next;
    logic [VW-1:0]   x1_reg, x1_next;
    logic [VW-1:0]   x2_reg, x2_next;
    logic [ModW-1:0] m_reg, m_next;
    logic [ModW-1:0] inv_reg, inv_next;
    logic            noinv_reg, noinv_next;

    logic [VW-1:0] a_in;
    logic [VW-1:0] m_ext;
    logic          op_is_u;
    logic          op_halve;
    logic [VW-1:0] big, small_op;
    logic [VW-1:0] xa, xb;
    logic [VW-1:0] uv_new;
    logic [VW:0]   xsum;
    logic [VW-1:0] x_half;
    logic [VW:0]   xdiff;
    logic [VW-1:0] x_wrap;
    logic [VW-1:0] x_sub;
    logic [VW-1:0] x_new;
    logic [VW-1:0] res;
    logic [VW:0]   rdiff;
    logic [VW-1:0] fin;

    // Request value masked to WIDTH bits.
    assign a_in  = VW'(value) & WMASK;
    assign m_ext = VW'(m_reg);

    // Input checks seen by the sequencer at accept time.
    assign status.in_bad = (a_in == '0) || !modulus[0] || (modulus < ModW'(3));
    assign status.u_one  = (u_reg == VW'(1));
    assign status.v_one  = (v_reg == VW'(1));
    assign status.u_zero = (u_reg == '0);
    assign status.v_zero = (v_reg == '0);
    assign status.u_even = !u_reg[0];
    assign status.v_even = !v_reg[0];
    assign status.u_ge_v = (u_reg >= v_reg);

    // Operand selection: the unit works on U/X1 or on V/X2.
    assign op_is_u  = (cmd.op == OP_HALVE_U) || (cmd.op == OP_SUB_U);
    assign op_halve = (cmd.op == OP_HALVE_U) || (cmd.op == OP_HALVE_V);
    assign big      = op_is_u ? u_reg : v_reg;
    assign small_op = op_is_u ? v_reg : u_reg;
    assign xa       = op_is_u ? x1_reg : x2_reg;
    assign xb       = op_is_u ? x2_reg : x1_reg;

    // U or V: halve, or subtract the smaller from the larger.
    assign uv_new = op_halve ? (big >> 1) : ((big - small_op) & WMASK);

    // X halving modulo the modulus; the carry out of the add is dropped.
    assign xsum   = {1'b0, xa} + {1'b0, (xa[0] ? m_ext : '0)};
    assign x_half = (xsum[VW-1:0] & WMASK) >> 1;

    // X modular subtract: add the modulus back on a borrow.
    assign xdiff  = {1'b0, xa} - {1'b0, xb};
    assign x_wrap = xdiff[VW-1:0] + m_ext;
    assign x_sub  = (xdiff[VW] ? x_wrap : xdiff[VW-1:0]) & WMASK;
    assign x_new  = op_halve ? x_half : x_sub;

    // Final pick and one conditional subtraction of the modulus.
    assign res   = status.u_one ? x1_reg : x2_reg;
    assign rdiff = {1'b0, res} - {1'b0, m_ext};
    assign fin   = rdiff[VW] ? res : rdiff[VW-1:0];

    // Next-state selection for the operand and result registers.
    always_comb
    begin
        u_next     = u_reg;
        v_next     = v_reg;
        x1_next    = x1_reg;
        x2_next    = x2_reg;
        m_next     = m_reg;
        inv_next   = inv_reg;
        noinv_next = noinv_reg;
        if (cmd.load)
        begin
            u_next  = a_in;
            v_next  = VW'(modulus);
            x1_next = VW'(1);
            x2_next = '0;
            m_next  = modulus;
        end
        else if (cmd.step)
        begin
            if (op_is_u)
            begin
                u_next  = uv_new;
                x1_next = x_new;
            end
            else
            begin
                v_next  = uv_new;
                x2_next = x_new;
            end
        end
        if (cmd.finish)
        begin
            inv_next   = fin[ModW-1:0];
            noinv_next = 1'b0;
        end
        else if (cmd.reject)
        begin
            inv_next   = '0;
            noinv_next = 1'b1;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        u_reg     <= u_next;
        v_reg     <= v_next;
        x1_reg    <= x1_next;
        x2_reg    <= x2_next;
        m_reg     <= m_next;
        inv_reg   <= inv_next;
        noinv_reg <= noinv_next;
    end

    assign inverse    = inv_reg;
    assign no_inverse = noinv_reg;

endmodule

FILE: rtl/bmi_ctrl.sv
// Sequencer of the binary modular inverse: handshake, step choice and step cap.
// Depends on bmi_pkg for the state, command and status types.
`timescale 1ns / 1ps

module bmi_ctrl
    import bmi_pkg::*;
#(
    parameter int MAX_STEPS = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    input  bmi_status_t status,
    output bmi_cmd_t    cmd
);

    localparam int CW = $clog2(MAX_STEPS + 1);

    bmi_state_t    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          cap_hit;

    // No request is taken while reset is applied.
    assign cap_hit   = (cnt_reg == CW'(MAX_STEPS));
    assign req_stall = !rst_n || (state_reg != ST_IDLE);
    assign rsp_valid = (state_reg == ST_DONE);

    // Step selection and state transitions.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '{load: 1'b0, step: 1'b0, finish: 1'b0, reject: 1'b0, op: OP_HALVE_U};
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (status.in_bad)
                    begin
                        cmd.reject = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        cmd.load   = 1'b1;
                        cnt_next   = '0;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                if (status.u_one || status.v_one)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_DONE;
                end
                else if (cap_hit || status.u_zero || status.v_zero)
                begin
                    cmd.reject = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.step = 1'b1;
                    cnt_next = cnt_reg + CW'(1);
                    if (status.u_even)
                    begin
                        cmd.op = OP_HALVE_U;
                    end
                    else if (status.v_even)
                    begin
                        cmd.op = OP_HALVE_V;
                    end
                    else if (status.u_ge_v)
                    begin
                        cmd.op = OP_SUB_U;
                    end
                    else
                    begin
                        cmd.op = OP_SUB_V;
                    end
                end
            end
            ST_DONE:
            begin
                if (!rsp_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

FILE: rtl/binary_modular_inverse.sv
// Top level of the binary extended-GCD modular inverse.
// Instantiates bmi_ctrl and bmi_datapath; uses bmi_pkg.
//
//  Channel   Signals                          Direction
//  request   req_valid, req_stall, value,     into the block
//            modulus
//  response  rsp_valid, rsp_stall, inverse,   out of the block
//            no_inverse
//
// One request is worked at a time. A request with a valid modulus is worked
// one GCD step per cycle by the single step unit, and the step count is
// capped at MAX_STEPS. A request rejected at entry has its response in the
// next cycle. req_stall is high from acceptance until the response is
// taken. Reset clears only the sequencer.
`timescale 1ns / 1ps

module binary_modular_inverse
    import bmi_pkg::*;
#(
    parameter int WIDTH     = 32,
    parameter int MAX_STEPS = 4096
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  logic [ValueW-1:0] value,
    input  logic [ModW-1:0]   modulus,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output logic [ModW-1:0]   inverse,
    output logic              no_inverse
);

    bmi_status_t status;
    bmi_cmd_t    cmd;

    // Sequencer.
    bmi_ctrl #(
        .MAX_STEPS (MAX_STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Operand registers and shared step unit.
    bmi_datapath #(
        .WIDTH (WIDTH)
    ) u_datapath (
        .clk        (clk),
        .value      (value),
        .modulus    (modulus),
        .cmd        (cmd),
        .status     (status),
        .inverse    (inverse),
        .no_inverse (no_inverse)
    );

    // A new request is never taken while a response is pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(req_valid && !req_stall && rsp_valid))
        else $error("request accepted while a response is pending");

    // A failed inverse always reads as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && no_inverse) |-> (inverse == '0))
        else $error("nonzero inverse reported with no_inverse set");

    // Once the response is taken the block is ready for the next request.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_stall) |=> (!req_stall && !rsp_valid))
        else $error("block not idle after the response was taken");

endmodule
